[hw/rtl/ble_pkg.sv]
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared constants, the voltage threshold table and the percent lookup.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int RAW_W   = 12;
    localparam int CAL_W   = 16;
    localparam int VOLT_W  = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = RAW_W + CAL_W;      // raw times calibration
    localparam int Y_W     = PROD_W - 3;         // product over eight
    localparam int QUOT_W  = 17;                 // largest quotient fits here
    localparam int RECIP_W = 17;
    localparam int RECIP_SHIFT = 25;

    localparam int TABLE_SIZE  = 10;
    localparam int LEVEL_COUNT = 10;

    localparam logic [CAL_W-1:0]   CAL_MIN  = 16'd1900;
    // Division by 2184 is a shift by three followed by division by 273.
    localparam logic [8:0]         DIV_ODD  = 9'd273;
    localparam logic [RECIP_W-1:0] RECIP    = 17'd122910;   // floor(2^25 / 273)

    typedef logic [VOLT_W-1:0] volt_t;
    typedef logic [PCT_W-1:0]  pct_t;

    localparam volt_t LEVEL_VOLTS [TABLE_SIZE] = '{
        16'd828, 16'd813, 16'd794, 16'd782, 16'd770,
        16'd758, 16'd750, 16'd742, 16'd734, 16'd726
    };
    localparam pct_t LEVEL_PCT [TABLE_SIZE] = '{
        7'd100, 7'd97, 7'd80, 7'd65, 7'd45,
        7'd25,  7'd18, 7'd12, 7'd9,  7'd6
    };

    // The first threshold reached, in descending order, gives the percent.
    function automatic pct_t percent_of(input volt_t avg);
        pct_t pct;
        pct = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if ((i < LEVEL_COUNT) && (avg >= LEVEL_VOLTS[i])) begin
                pct = LEVEL_PCT[i];
            end
        end
        return pct;
    endfunction

endpackage

[hw/rtl/ble_scaler.sv]
// ----------------------------------------------------------------------------
// Battery level estimator: sample scaler
// Three-stage pipeline that multiplies the raw sample by the calibration
// value, divides by 2184 through a reciprocal and saturates to 16 bits; a
// calibration below CAL_MIN passes the raw sample through instead.
module ble_scaler
    import ble_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CAL_W-1:0]  calibration,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAW_W-1:0]  adc_raw,
    output logic              out_valid,
    input  logic              out_ready,
    output volt_t             sample
);

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    logic              a_free, b_free, c_free;

    logic [PROD_W-1:0] prod_reg;
    logic              a_bypass_reg, b_bypass_reg;
    logic [RAW_W-1:0]  a_raw_reg, b_raw_reg;

    logic [Y_W-1:0]    y_reg;
    logic [QUOT_W-1:0] est_reg;
    volt_t             sample_reg;

    logic [Y_W+RECIP_W-1:0] recip_prod;
    logic [Y_W:0]           est_times;
    logic [Y_W:0]           rem;
    logic [QUOT_W-1:0]      quot;
    volt_t                  scaled_next;

    assign c_free   = !c_valid_reg || out_ready;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_ready = a_free;

    assign out_valid = c_valid_reg;
    assign sample    = sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= in_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Stage A: full product of sample and calibration.
    always_ff @(posedge aclk) begin
        if (a_free && in_valid) begin
            prod_reg     <= PROD_W'(adc_raw) * PROD_W'(calibration);
            a_bypass_reg <= (calibration < CAL_MIN);
            a_raw_reg    <= adc_raw;
        end
    end

    // Stage B: quotient estimate, which is either exact or one short.
    assign recip_prod = (Y_W+RECIP_W)'(prod_reg[PROD_W-1:3]) * (Y_W+RECIP_W)'(RECIP);

    always_ff @(posedge aclk) begin
        if (b_free && a_valid_reg) begin
            y_reg        <= prod_reg[PROD_W-1:3];
            est_reg      <= recip_prod[RECIP_SHIFT +: QUOT_W];
            b_bypass_reg <= a_bypass_reg;
            b_raw_reg    <= a_raw_reg;
        end
    end

    // Stage C: correct the estimate by one compare and saturate.
    always_comb begin
        est_times = ((Y_W+1)'(est_reg) << 8) + ((Y_W+1)'(est_reg) << 4)
                  + (Y_W+1)'(est_reg);
        rem       = {1'b0, y_reg} - est_times;
        quot      = (rem >= (Y_W+1)'(DIV_ODD)) ? est_reg + QUOT_W'(1) : est_reg;
        if (b_bypass_reg) begin
            scaled_next = VOLT_W'(b_raw_reg);
        end else if (quot[QUOT_W-1:VOLT_W] != '0) begin
            scaled_next = '1;
        end else begin
            scaled_next = quot[VOLT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_free && b_valid_reg) begin
            sample_reg <= scaled_next;
        end
    end

endmodule

[hw/rtl/ble_average.sv]
// ----------------------------------------------------------------------------
// Battery level estimator: averager and level lookup
// Updates the running average and registers the result with its percent.
// ----------------------------------------------------------------------------
module ble_average
    import ble_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  volt_t sample,
    output logic  out_valid,
    input  logic  out_ready,
    output volt_t voltage_avg,
    output pct_t  charge_percent
);

    logic              valid_reg;
    volt_t             avg_reg;
    volt_t             avg_next;
    pct_t              pct_reg;
    volt_t             base;
    logic [VOLT_W+1:0] acc;
    logic              take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // A zero average means unseeded, so the sample itself is the base.
    always_comb begin
        base     = (avg_reg == '0) ? sample : avg_reg;
        acc      = ((VOLT_W+2)'(base) << 1) + (VOLT_W+2)'(base) + (VOLT_W+2)'(sample);
        avg_next = acc[VOLT_W+1:2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            avg_reg   <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (take) begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pct_reg <= percent_of(avg_next);
        end
    end

    assign out_valid      = valid_reg;
    assign voltage_avg    = avg_reg;
    assign charge_percent = pct_reg;

endmodule

[hw/rtl/battery_level_estimator_top.sv]
// ----------------------------------------------------------------------------
// Battery level estimator
// Calibrated running average of battery samples with a charge estimate.
// ----------------------------------------------------------------------------
// Accepts one ADC sample per clock unless a stalled result holds the
// pipeline, and returns one result per sample. Each sample passes through
// the scaling pipeline: one stage for the calibration product, one for the
// reciprocal multiply that divides by 2184 and one for the correction step,
// followed by the averaging stage that also holds the result. Each stage
// stalls on its own, so gaps inside the pipeline close up while a result
// waits to be taken.
module battery_level_estimator_top
    import ble_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CAL_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [RAW_W-1:0] s_adc_raw,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VOLT_W-1:0] m_voltage_avg,
    output logic [PCT_W-1:0] m_charge_percent
);

    logic [CAL_W-1:0] calibration_reg;
    logic             scl_valid;
    logic             scl_ready;
    volt_t            scl_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibration_reg <= '0;
        end else if (cfg_we) begin
            calibration_reg <= cfg_wdata;
        end
    end

    ble_scaler u_scaler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .calibration (calibration_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .adc_raw     (s_adc_raw),
        .out_valid   (scl_valid),
        .out_ready   (scl_ready),
        .sample      (scl_sample)
    );

    ble_average u_average (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (scl_valid),
        .in_ready       (scl_ready),
        .sample         (scl_sample),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .voltage_avg    (m_voltage_avg),
        .charge_percent (m_charge_percent)
    );

endmodule

[hw/rtl/ble_checker.sv]
// ----------------------------------------------------------------------------
// Battery level estimator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ble_checker
    import ble_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [VOLT_W-1:0] m_voltage_avg,
    input logic [PCT_W-1:0]  m_charge_percent
);

    // No result may be offered straight after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_voltage_avg)
                                && $stable(m_charge_percent))
        else $error("stalled result changed");

    // An average at or above the top threshold is a full battery.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_voltage_avg >= LEVEL_VOLTS[0]) |-> m_charge_percent == 7'd100)
        else $error("full battery not reported as full");

    // Below the lowest threshold the charge is empty.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_voltage_avg < LEVEL_VOLTS[TABLE_SIZE-1]) |->
            m_charge_percent == 7'd0)
        else $error("empty battery reported with charge");

endmodule

bind battery_level_estimator_top ble_checker u_ble_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_voltage_avg    (m_voltage_avg),
    .m_charge_percent (m_charge_percent)
);
